// ===== rtl/rcpwm_pkg.sv =====
// shared types and constants for the rc pwm capture block
`timescale 1ns / 1ps

package rcpwm_pkg;

  localparam int PIN_BITS    = 4;
  localparam int TIME_W      = 32;
  localparam int WIDTH_W     = 32;
  localparam int COUNT_W     = 16;
  localparam int OUT_SLOTS   = 4;
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 136;

  localparam logic [COUNT_W-1:0] THRESHOLD_RESET = 16'd300;
  localparam logic [COUNT_W-1:0] COUNT_MAX       = 16'hFFFF;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_CHECK  = 1'b1;

  typedef struct packed {
    logic              sample;
    logic              level;
    logic [TIME_W-1:0] time_us;
  } cap_req_t;

endpackage

// ===== rtl/rc_pwm_capture_with_failsafe.sv =====
// top level: rc pwm width capture with connection failsafe
// path: a request passes through the input register and then the result register to result valid
// throughput: one request per cycle while results are taken, set by the single-pass edge and counter logic
// a stalled result holds the result register; one more request waits in the input register
// reset (rst, synchronous): clears levels, start times, widths, snapshot and counter,
// loads threshold 300, and empties both pipeline registers
`timescale 1ns / 1ps

module rc_pwm_capture_with_failsafe #(
  parameter int CHANNELS = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [3:0] pin_levels, [35:4] time_us, [39:36] zero
  input  logic [rcpwm_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // [0] operation
  input  logic                              s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] width_ch0, [63:32] width_ch1, [95:64] width_ch2, [127:96] width_ch3,
  // [128] connected, [135:129] zero
  output logic [rcpwm_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                              cfg_wr_en,
  input  logic [rcpwm_pkg::COUNT_W-1:0]     cfg_wr_data
);
  import rcpwm_pkg::*;

  logic                   s1_valid;
  logic                   s1_op;
  logic [PIN_BITS-1:0]    s1_levels;
  logic [TIME_W-1:0]      s1_time;
  logic                   advance;
  logic                   connected_next;
  logic [PIN_BITS-1:0]    snap;
  logic [CHANNELS-1:0]    level_vec;
  logic [WIDTH_W-1:0]     width_next [CHANNELS];
  logic [OUT_TDATA_W-1:0] result_data;

  assign advance       = s1_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      s1_op     <= s_axis_tuser;
      s1_levels <= s_axis_tdata[PIN_BITS-1:0];
      s1_time   <= s_axis_tdata[PIN_BITS +: TIME_W];
    end
  end

  genvar g;
  generate
    for (g = 0; g < CHANNELS; g++) begin : g_ch
      cap_req_t req;
      assign req.sample  = advance && (s1_op == OP_SAMPLE);
      assign req.time_us = s1_time;
      if (g < PIN_BITS) begin : g_pin
        assign req.level = s1_levels[g];
      end else begin : g_nopin
        assign req.level = 1'b0;
      end
      rcpwm_capture u_capture (
        .clk        (clk),
        .rst        (rst),
        .req        (req),
        .level      (level_vec[g]),
        .width_next (width_next[g])
      );
    end

    for (g = 0; g < PIN_BITS; g++) begin : g_snap
      if (g < CHANNELS) begin : g_on
        assign snap[g] = level_vec[g];
      end else begin : g_off
        assign snap[g] = 1'b0;
      end
    end

    for (g = 0; g < OUT_SLOTS; g++) begin : g_slot
      if (g < CHANNELS) begin : g_on
        assign result_data[g*WIDTH_W +: WIDTH_W] = width_next[g];
      end else begin : g_off
        assign result_data[g*WIDTH_W +: WIDTH_W] = '0;
      end
    end
  endgenerate

  assign result_data[OUT_SLOTS*WIDTH_W] = connected_next;
  assign result_data[OUT_TDATA_W-1:OUT_SLOTS*WIDTH_W+1] = '0;

  rcpwm_failsafe u_failsafe (
    .clk            (clk),
    .rst            (rst),
    .check          (advance && (s1_op == OP_CHECK)),
    .snap           (snap),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .connected_next (connected_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= result_data;
    end
  end

`ifndef SYNTHESIS
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

  a_pending_moves: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !m_axis_tvalid |=> m_axis_tvalid)
    else $error("pending request did not reach result register");

  a_stall_holds_stage: assert property (@(posedge clk) disable iff (rst)
    s1_valid && m_axis_tvalid && !m_axis_tready |=> s1_valid && $stable(s1_time))
    else $error("input register lost a request under stall");
`endif

endmodule

// ===== rtl/rcpwm_capture.sv =====
// one channel of pulse edge tracking and width latching
`timescale 1ns / 1ps

module rcpwm_capture (
  input  logic                            clk,
  input  logic                            rst,
  input  rcpwm_pkg::cap_req_t             req,
  output logic                            level,
  output logic [rcpwm_pkg::WIDTH_W-1:0]   width_next
);
  import rcpwm_pkg::*;

  logic [TIME_W-1:0]  rise_time;
  logic [WIDTH_W-1:0] width;
  logic               rising;
  logic               falling;

  assign rising     = req.sample & ~level & req.level;
  assign falling    = req.sample & level & ~req.level;
  assign width_next = falling ? (req.time_us - rise_time) : width;

  always_ff @(posedge clk) begin
    if (rst) begin
      level     <= 1'b0;
      rise_time <= '0;
      width     <= '0;
    end else begin
      if (rising) begin
        level     <= 1'b1;
        rise_time <= req.time_us;
      end else if (falling) begin
        level <= 1'b0;
      end
      width <= width_next;
    end
  end

endmodule

// ===== rtl/rcpwm_failsafe.sv =====
// stuck-input counter, threshold register and connection flag
`timescale 1ns / 1ps

module rcpwm_failsafe (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           check,
  input  logic [rcpwm_pkg::PIN_BITS-1:0] snap,
  input  logic                           cfg_wr_en,
  input  logic [rcpwm_pkg::COUNT_W-1:0]  cfg_wr_data,
  output logic                           connected_next
);
  import rcpwm_pkg::*;

  logic [PIN_BITS-1:0] previous_snapshot;
  logic [COUNT_W-1:0]  stuck_count;
  logic [COUNT_W-1:0]  stuck_count_next;
  logic [COUNT_W-1:0]  threshold;
  logic                same;

  assign same = (snap == previous_snapshot);

  always_comb begin
    stuck_count_next = stuck_count;
    if (check) begin
      if (!same) begin
        stuck_count_next = '0;
      end else if (stuck_count != COUNT_MAX) begin
        stuck_count_next = stuck_count + 1'b1;
      end
    end
  end

  assign connected_next = (stuck_count_next < threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_snapshot <= '0;
      stuck_count       <= '0;
      threshold         <= THRESHOLD_RESET;
    end else begin
      stuck_count <= stuck_count_next;
      if (check) begin
        previous_snapshot <= snap;
      end
      if (cfg_wr_en) begin
        threshold <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_count_only_on_check: assert property (@(posedge clk) disable iff (rst)
    !check |=> $stable(stuck_count))
    else $error("stuck count moved without a check");

  a_count_saturates: assert property (@(posedge clk) disable iff (rst)
    check && same && stuck_count == COUNT_MAX |=> stuck_count == COUNT_MAX)
    else $error("stuck count wrapped");

  a_zero_threshold: assert property (@(posedge clk) disable iff (rst)
    threshold == '0 |-> !connected_next)
    else $error("connected with zero threshold");
`endif

endmodule

// ===== tb/tb_rc_pwm_capture_with_failsafe.sv =====
// testbench for the rc pwm capture block: directed table, random pulse trains, failsafe counter
`timescale 1ns / 1ps

module tb_rc_pwm_capture_with_failsafe;
  import rcpwm_pkg::*;

  localparam int CHANNELS = 4;

  typedef struct packed {
    logic                              connected;
    logic [OUT_SLOTS-1:0][WIDTH_W-1:0] width;
  } pwm_result_t;

  typedef struct packed {
    logic               op;
    logic [PIN_BITS-1:0] lv;
    logic [TIME_W-1:0]  tm;
    logic               typed;
    pwm_result_t        want;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = OP_SAMPLE;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [COUNT_W-1:0]     cfg_wr_data = '0;

  rc_pwm_capture_with_failsafe #(.CHANNELS(CHANNELS)) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // predictor state
  logic [CHANNELS-1:0]  level_q;
  logic [TIME_W-1:0]    start_q [CHANNELS];
  logic [WIDTH_W-1:0]   width_q [CHANNELS];
  logic [PIN_BITS-1:0]  snap_q;
  logic [COUNT_W-1:0]   stuck_q;
  logic [COUNT_W-1:0]   threshold_q;

  pwm_result_t widths_due[$];
  dir_row_t    dir_rows[$];
  int unsigned errors = 0;
  int unsigned sent_n = 0;
  int unsigned got_n = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("rc_pwm_capture_with_failsafe: mismatch");
    $finish;
  end

  function automatic void clear_predictor();
    level_q = '0;
    for (int i = 0; i < CHANNELS; i++) begin
      start_q[i] = '0;
      width_q[i] = '0;
    end
    snap_q = '0;
    stuck_q = '0;
    threshold_q = THRESHOLD_RESET;
  endfunction

  function automatic pwm_result_t predict_capture(logic op, logic [PIN_BITS-1:0] lv,
                                                  logic [TIME_W-1:0] tm);
    pwm_result_t r;
    logic [PIN_BITS-1:0] snap;
    r = '0;
    snap = '0;
    if (op == OP_SAMPLE) begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (!level_q[i] && lv[i]) begin
          level_q[i] = 1'b1;
          start_q[i] = tm;
        end else if (level_q[i] && !lv[i]) begin
          level_q[i] = 1'b0;
          width_q[i] = tm - start_q[i];
        end
      end
    end else begin
      for (int i = 0; i < CHANNELS && i < PIN_BITS; i++) snap[i] = level_q[i];
      if (snap == snap_q) begin
        if (stuck_q != COUNT_MAX) stuck_q = stuck_q + 1'b1;
      end else begin
        stuck_q = '0;
      end
      snap_q = snap;
    end
    for (int i = 0; i < CHANNELS && i < OUT_SLOTS; i++) r.width[i] = width_q[i];
    r.connected = (stuck_q < threshold_q);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    if (errors <= 50) $display("result %0d %s: got %h want %h", got_n, what, got, want);
  endtask

  function automatic pwm_result_t typed_result(logic [31:0] w0, logic [31:0] w1,
                                               logic [31:0] w2, logic [31:0] w3, logic conn);
    pwm_result_t r;
    r = '0;
    r.width[0] = w0;
    r.width[1] = w1;
    r.width[2] = w2;
    r.width[3] = w3;
    r.connected = conn;
    return r;
  endfunction

  function automatic void add_row(logic op, logic [PIN_BITS-1:0] lv, logic [TIME_W-1:0] tm,
                                  logic typed, pwm_result_t want);
    dir_row_t row;
    row.op = op;
    row.lv = lv;
    row.tm = tm;
    row.typed = typed;
    row.want = want;
    dir_rows.push_back(row);
  endfunction

  function automatic bit calm_window(int unsigned n);
    return n >= 400 && n < 650;
  endfunction

  // a request stays offered until accepted; valid only drops on a gap
  task automatic send_item(input logic op, input logic [PIN_BITS-1:0] lv,
                           input logic [TIME_W-1:0] tm, input logic typed,
                           input pwm_result_t want);
    pwm_result_t p;
    while (!calm_window(sent_n) && $urandom_range(0, 99) < 37) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {4'b0, tm, lv};
    do @(posedge clk); while (!s_axis_tready);
    p = predict_capture(op, lv, tm);
    widths_due.push_back(typed ? want : p);
    sent_n++;
  endtask

  task automatic send(input logic op, input logic [PIN_BITS-1:0] lv, input logic [TIME_W-1:0] tm);
    send_item(op, lv, tm, 1'b0, '0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (widths_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [COUNT_W-1:0] v);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    threshold_q = v;
  endtask

  // pulse trains with random content, bursts of checks, and some noise
  task automatic random_pulses(input int n, input logic [TIME_W-1:0] t0);
    logic [PIN_BITS-1:0] lv;
    logic [TIME_W-1:0]   tm;
    int k;
    int r;
    int burst;
    lv = level_q;
    tm = t0;
    k = 0;
    while (k < n) begin
      r = $urandom_range(0, 99);
      if (r < 12) begin
        burst = $urandom_range(1, 12);
        repeat (burst) begin
          send(OP_CHECK, 4'($urandom), $urandom);
          k++;
        end
      end else if (r < 22) begin
        send(OP_CHECK, 4'($urandom), $urandom);
        k++;
      end else if (r < 32) begin
        lv = 4'($urandom);
        send(OP_SAMPLE, lv, $urandom);
        k++;
      end else begin
        tm = tm + $urandom_range(1, 2500);
        for (int i = 0; i < PIN_BITS; i++)
          if ($urandom_range(0, 9) < 3) lv[i] = ~lv[i];
        send(OP_SAMPLE, lv, tm);
        k++;
      end
    end
  endtask

  // result side
  initial begin
    pwm_result_t got;
    pwm_result_t want;
    int unsigned hold_left;
    bit held;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata[128], m_axis_tdata[127:0]};
        if (widths_due.size() == 0) begin
          report_mismatch("unexpected", got.width[0], '0);
        end else begin
          want = widths_due.pop_front();
          for (int i = 0; i < OUT_SLOTS; i++)
            if (got.width[i] !== want.width[i])
              report_mismatch($sformatf("width_ch%0d", i), got.width[i], want.width[i]);
          if (got.connected !== want.connected)
            report_mismatch("connected", {31'b0, got.connected}, {31'b0, want.connected});
        end
        got_n++;
      end
      if (!held && got_n == 800) begin
        held = 1'b1;
        hold_left = 200;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (calm_window(got_n)) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 37);
      end
    end
  end

  // request side
  initial begin
    clear_predictor();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_SAMPLE, 4'h0, 32'h0000_0000, 1'b1, typed_result(0, 0, 0, 0, 1'b1));
    add_row(OP_CHECK,  4'h0, 32'h0000_0000, 1'b1, typed_result(0, 0, 0, 0, 1'b1));
    add_row(OP_SAMPLE, 4'hF, 32'hFFFF_FFF0, 1'b1, typed_result(0, 0, 0, 0, 1'b1));
    add_row(OP_SAMPLE, 4'hF, 32'h0000_0005, 1'b1, typed_result(0, 0, 0, 0, 1'b1));
    add_row(OP_SAMPLE, 4'h0, 32'h0000_0010, 1'b1,
            typed_result(32'h20, 32'h20, 32'h20, 32'h20, 1'b1));
    add_row(OP_CHECK,  4'hF, 32'hFFFF_FFFF, 1'b1,
            typed_result(32'h20, 32'h20, 32'h20, 32'h20, 1'b1));
    add_row(OP_SAMPLE, 4'h1, 32'd100, 1'b0, '0);
    add_row(OP_CHECK,  4'hF, 32'h1234_5678, 1'b0, '0);
    add_row(OP_SAMPLE, 4'hA, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h5, 32'h0000_0000, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h0, 32'h0000_0000, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h8, 32'h8000_0000, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h0, 32'h7FFF_FFFF, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h6, 32'h5555_AAAA, 1'b0, '0);
    add_row(OP_CHECK,  4'h0, 32'h0000_0000, 1'b0, '0);
    add_row(OP_CHECK,  4'h0, 32'h0000_0000, 1'b0, '0);
    add_row(OP_CHECK,  4'hF, 32'hFFFF_FFFF, 1'b0, '0);
    add_row(OP_SAMPLE, 4'h9, 32'hAAAA_5555, 1'b0, '0);
    add_row(OP_CHECK,  4'h0, 32'h0000_0000, 1'b0, '0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].op, dir_rows[i].lv, dir_rows[i].tm, dir_rows[i].typed,
                dir_rows[i].want);

    // zero threshold: never connected
    write_threshold(16'd0);
    random_pulses(30, $urandom);
    write_threshold(16'd1);
    random_pulses(30, 32'h0000_0000);

    write_threshold(16'($urandom_range(2, 12)));
    random_pulses(275, 32'hFFFF_F000);
    write_threshold(16'd2);
    random_pulses(275, $urandom);
    write_threshold(16'($urandom_range(0, 65535)));
    random_pulses(275, $urandom);
    write_threshold(16'd3);
    random_pulses(275, $urandom);

    // top threshold
    write_threshold(COUNT_MAX);
    random_pulses(20, $urandom);

    drain();
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("rc_pwm_capture_with_failsafe: match");
    end else begin
      $display("rc_pwm_capture_with_failsafe: mismatch");
    end
    $finish;
  end

endmodule
